// File: hw/rtl/bdsp_pkg.sv
// Shared types and constants of the bus decode and system ports block.
package bdsp_pkg;

   localparam int RAM_WORDS = 65536;
   localparam int ROM_WORDS = 2048;
   localparam int RAM_AW    = $clog2(RAM_WORDS);
   localparam int ROM_AW    = $clog2(ROM_WORDS);

   // Bus addresses (octal map)
   localparam logic [15:0] ADDR_ROM_LO    = 16'o160000;
   localparam logic [15:0] ADDR_ROM_HI    = 16'o170000;
   localparam logic [15:0] ADDR_TRAP_LO   = 16'o177560;
   localparam logic [15:0] ADDR_TRAP_HI   = 16'o177567;
   localparam logic [15:0] ADDR_TRAP_B12  = 16'o177560;
   localparam logic [15:0] ADDR_TRAP_B13  = 16'o177562;
   localparam logic [15:0] ADDR_TRAP_NOHR = 16'o177564;
   localparam logic [15:0] ADDR_TRAP_B14  = 16'o177566;
   localparam logic [15:0] ADDR_STATUS    = 16'o170006;
   localparam logic [15:0] ADDR_NET0      = 16'o170010;
   localparam logic [15:0] ADDR_NET1      = 16'o170012;
   localparam logic [15:0] ADDR_IO1_LO    = 16'o170006;
   localparam logic [15:0] ADDR_IO1_HI    = 16'o170013;
   localparam logic [15:0] ADDR_PRN_LO    = 16'o177514;
   localparam logic [15:0] ADDR_PRN_HI    = 16'o177517;
   localparam logic [15:0] ADDR_PSTAT     = 16'o177514;
   localparam logic [15:0] ADDR_PDATA     = 16'o177516;
   localparam logic [15:0] ADDR_IND_LO    = 16'o177570;
   localparam logic [15:0] ADDR_IND_HI    = 16'o177573;
   localparam logic [15:0] ADDR_IDATA     = 16'o177570;
   localparam logic [15:0] ADDR_IADDR     = 16'o177572;
   localparam logic [15:0] ADDR_FDC_LO    = 16'o177100;
   localparam logic [15:0] ADDR_FDC_HI    = 16'o177107;

   // Register values and masks
   localparam logic [15:0] HALT_STATUS_RST = 16'o100000;
   localparam logic [14:0] PSTAT_RST       = 15'o377;
   localparam logic [14:0] PSTAT_KEEP      = 15'o277;
   localparam logic [14:0] PSTAT_WMASK     = 15'o37600;
   localparam logic [14:0] PSTAT_DONE_BUSY = 15'o240;
   localparam logic [14:0] PSTAT_BUSY      = 15'o40;
   localparam logic [14:0] PSTAT_DONE      = 15'o200;
   localparam logic [15:0] KEY_FLAG        = 16'o2000;
   localparam logic [15:0] TRAP_FLAG12     = 16'o10000;
   localparam logic [15:0] TRAP_FLAG13     = 16'o20000;
   localparam logic [15:0] TRAP_FLAG14     = 16'o40000;

   typedef enum logic [2:0] {
      FN_RD_WORD = 3'd0,
      FN_RD_BYTE = 3'd1,
      FN_WR_WORD = 3'd2,
      FN_WR_BYTE = 3'd3,
      FN_TICK    = 3'd4,
      FN_KEY     = 3'd5,
      FN_ROM_LD  = 3'd6,
      FN_NOP     = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      KIND_RAM  = 2'd0,
      KIND_ROM  = 2'd1,
      KIND_IO   = 2'd2,
      KIND_TRAP = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PORT_NONE   = 3'd0,
      PORT_STATUS = 3'd1,
      PORT_NET    = 3'd2,
      PORT_FDC    = 3'd3,
      PORT_PSTAT  = 3'd4,
      PORT_PDATA  = 3'd5,
      PORT_IADDR  = 3'd6,
      PORT_IDATA  = 3'd7
   } port_type;

   // Classified bus word handed from front to back
   typedef struct packed {
      func_type    func;
      logic [15:0] address;
      logic [15:0] wdata;
      kind_type    kind;
      port_type    port;
      logic        key_pressed;
      logic        clear_halt;
   } item_type;

endpackage

// File: hw/rtl/bdsp_front.sv
// Front end: accept request words, decode address kind and port, queue them.
module bdsp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_func,
   input  logic [15:0]        req_address,
   input  logic [15:0]        req_wdata,
   input  logic               req_halt_mode,
   input  logic               req_key_pressed,
   input  logic               req_clear_halt,
   output logic               head_valid,
   output bdsp_pkg::item_type head_item,
   input  logic               head_pop
);

   bdsp_pkg::item_type q_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   bdsp_pkg::item_type item;
   logic [15:0]        base;
   logic               push;

   // Decode address into kind and port
   always_comb begin
      base             = {req_address[15:1], 1'b0};
      item.func        = bdsp_pkg::func_type'(req_func);
      item.address     = req_address;
      item.wdata       = req_wdata;
      item.key_pressed = req_key_pressed;
      item.clear_halt  = req_clear_halt;
      if (req_address < bdsp_pkg::ADDR_ROM_LO) begin
         item.kind = bdsp_pkg::KIND_RAM;
      end else if (req_address < bdsp_pkg::ADDR_ROM_HI) begin
         item.kind = bdsp_pkg::KIND_ROM;
      end else if (!req_halt_mode && req_address >= bdsp_pkg::ADDR_TRAP_LO &&
                   req_address <= bdsp_pkg::ADDR_TRAP_HI) begin
         item.kind = bdsp_pkg::KIND_TRAP;
      end else if ((req_address >= bdsp_pkg::ADDR_IO1_LO &&
                    req_address <= bdsp_pkg::ADDR_IO1_HI) ||
                   (req_address >= bdsp_pkg::ADDR_PRN_LO &&
                    req_address <= bdsp_pkg::ADDR_PRN_HI) ||
                   (req_address >= bdsp_pkg::ADDR_IND_LO &&
                    req_address <= bdsp_pkg::ADDR_IND_HI) ||
                   (req_address >= bdsp_pkg::ADDR_FDC_LO &&
                    req_address <= bdsp_pkg::ADDR_FDC_HI)) begin
         item.kind = bdsp_pkg::KIND_IO;
      end else begin
         item.kind = bdsp_pkg::KIND_RAM;
      end
      // A word access at an odd address hits no port
      if (req_address[0] && !req_func[0]) begin
         item.port = bdsp_pkg::PORT_NONE;
      end else if (base == bdsp_pkg::ADDR_STATUS) begin
         item.port = bdsp_pkg::PORT_STATUS;
      end else if (base == bdsp_pkg::ADDR_NET0 || base == bdsp_pkg::ADDR_NET1) begin
         item.port = bdsp_pkg::PORT_NET;
      end else if (base >= bdsp_pkg::ADDR_FDC_LO && base <= bdsp_pkg::ADDR_FDC_HI) begin
         item.port = bdsp_pkg::PORT_FDC;
      end else if (base == bdsp_pkg::ADDR_PSTAT) begin
         item.port = bdsp_pkg::PORT_PSTAT;
      end else if (base == bdsp_pkg::ADDR_PDATA) begin
         item.port = bdsp_pkg::PORT_PDATA;
      end else if (base == bdsp_pkg::ADDR_IADDR) begin
         item.port = bdsp_pkg::PORT_IADDR;
      end else if (base == bdsp_pkg::ADDR_IDATA) begin
         item.port = bdsp_pkg::PORT_IDATA;
      end else begin
         item.port = bdsp_pkg::PORT_NONE;
      end
   end

   // Queue control
   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ head_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, head_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// File: hw/rtl/bdsp_back.sv
// Back end: execute queued words against RAM, ROM and port registers.
module bdsp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic               csr_wdata,
   input  logic               head_valid,
   input  bdsp_pkg::item_type head_item,
   output logic               head_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_rdata,
   output logic [1:0]         rsp_addr_kind,
   output logic               rsp_mem_error,
   output logic               rsp_halt_request,
   output logic               rsp_halt_mode_write,
   output logic               rsp_halt_mode_value,
   output logic               rsp_printer_strobe,
   output logic [7:0]         rsp_printer_byte,
   output logic               rsp_printer_irq
);

   typedef enum logic [1:0] {SRC_REG, SRC_RAM, SRC_ROM} src_type;

   logic [15:0] ram_mem [bdsp_pkg::RAM_WORDS];
   logic [15:0] rom_mem [bdsp_pkg::ROM_WORDS];
   logic [15:0] ram_q_ff, rom_q_ff;

   logic        attached_ff;
   logic [15:0] hstat_ff, hstat_in;
   logic [15:0] iaddr_ff, iaddr_in;
   logic [14:0] pstat_ff, pstat_in;
   logic [7:0]  pdata_ff, pdata_in;

   logic        valid_ff;
   src_type     src_ff, src_in;
   logic        bsel_ff, bsel_in;
   logic        odd_ff, odd_in;
   logic [15:0] rval_ff, rval_in;
   logic [1:0]  kind_ff, kind_in;
   logic        err_ff, err_in;
   logic        hreq_ff, hreq_in;
   logic        hmw_ff, hmw_in;
   logic        hmv_ff, hmv_in;
   logic        strb_ff, strb_in;
   logic [7:0]  pbyte_ff, pbyte_in;
   logic        irq_ff, irq_in;

   logic                        fire;
   logic                        is_bus, is_write, is_byte;
   logic                        ram_rd, ram_wr, rom_rd;
   logic [bdsp_pkg::RAM_AW-1:0] ram_addr;
   logic [1:0]                  ram_be;
   logic [15:0]                 ram_wd;
   logic [15:0]                 pval, pw;
   logic [16:0]                 bus_idx;
   logic [14:0]                 pst;
   logic [15:0]                 rword;

   assign fire     = head_valid && (!valid_ff || !rsp_stall);
   assign head_pop = fire;

   // Execute the head word
   always_comb begin
      is_bus   = (head_item.func <= bdsp_pkg::FN_WR_BYTE);
      is_write = head_item.func[1];
      is_byte  = head_item.func[0];
      hstat_in = hstat_ff;
      iaddr_in = iaddr_ff;
      pstat_in = pstat_ff;
      pdata_in = pdata_ff;
      src_in   = SRC_REG;
      bsel_in  = 1'b0;
      odd_in   = head_item.address[0];
      rval_in  = 16'd0;
      kind_in  = 2'd0;
      err_in   = 1'b0;
      hreq_in  = 1'b0;
      hmw_in   = 1'b0;
      hmv_in   = 1'b0;
      strb_in  = 1'b0;
      pbyte_in = 8'd0;
      irq_in   = 1'b0;
      ram_rd   = 1'b0;
      ram_wr   = 1'b0;
      rom_rd   = 1'b0;
      bus_idx  = {2'b00, head_item.address[15:1]};
      ram_addr = bus_idx[bdsp_pkg::RAM_AW-1:0];
      ram_be   = 2'b11;
      ram_wd   = head_item.wdata;
      pw       = head_item.wdata;
      pst      = pstat_ff;

      // Current port value, before any write
      case (head_item.port)
         bdsp_pkg::PORT_STATUS: pval = hstat_ff;
         bdsp_pkg::PORT_NET:    pval = 16'hffff;
         bdsp_pkg::PORT_PSTAT:  pval = {!attached_ff, pstat_ff};
         bdsp_pkg::PORT_IADDR:  pval = iaddr_ff;
         default:               pval = 16'd0;
      endcase

      if (is_bus) begin
         kind_in = head_item.kind;
         bsel_in = is_byte && !is_write;
         // RAM byte lanes for byte writes
         if (is_byte) begin
            ram_be = head_item.address[0] ? 2'b10 : 2'b01;
            ram_wd = {head_item.wdata[7:0], head_item.wdata[7:0]};
         end
         case (head_item.kind)
            bdsp_pkg::KIND_RAM, bdsp_pkg::KIND_TRAP: begin
               ram_wr = is_write;
               ram_rd = !is_write;
               src_in = is_write ? SRC_REG : SRC_RAM;
               if (head_item.kind == bdsp_pkg::KIND_TRAP) begin
                  if (head_item.address == bdsp_pkg::ADDR_TRAP_B12) begin
                     hstat_in = hstat_ff | bdsp_pkg::TRAP_FLAG12;
                  end else if (head_item.address == bdsp_pkg::ADDR_TRAP_B13) begin
                     hstat_in = hstat_ff | bdsp_pkg::TRAP_FLAG13;
                  end else if (head_item.address == bdsp_pkg::ADDR_TRAP_B14) begin
                     hstat_in = hstat_ff | bdsp_pkg::TRAP_FLAG14;
                  end
                  hreq_in = (head_item.address != bdsp_pkg::ADDR_TRAP_NOHR);
               end
            end
            bdsp_pkg::KIND_ROM: begin
               err_in = is_write;
               rom_rd = !is_write;
               src_in = is_write ? SRC_REG : SRC_ROM;
            end
            default: begin
               // Port access; merge byte writes into the port word
               err_in = (head_item.port == bdsp_pkg::PORT_NONE);
               if (is_byte) begin
                  pw = head_item.address[0] ? {head_item.wdata[7:0], pval[7:0]}
                                            : {pval[15:8], head_item.wdata[7:0]};
               end
               ram_addr = iaddr_ff[bdsp_pkg::RAM_AW-1:0];
               if (!is_write) begin
                  if (head_item.port == bdsp_pkg::PORT_IDATA) begin
                     ram_rd = 1'b1;
                     src_in = SRC_RAM;
                  end else begin
                     rval_in = pval;
                  end
               end else begin
                  case (head_item.port)
                     bdsp_pkg::PORT_STATUS: begin
                        hstat_in = 16'd0;
                        hmw_in   = 1'b1;
                        hmv_in   = (pw[1:0] != 2'b00);
                     end
                     bdsp_pkg::PORT_PSTAT: begin
                        pstat_in = (pstat_ff & bdsp_pkg::PSTAT_KEEP) |
                                   (pw[14:0] & bdsp_pkg::PSTAT_WMASK);
                     end
                     bdsp_pkg::PORT_PDATA: begin
                        pdata_in = pw[7:0];
                        pstat_in = pstat_ff & ~bdsp_pkg::PSTAT_DONE_BUSY;
                     end
                     bdsp_pkg::PORT_IADDR: iaddr_in = pw;
                     bdsp_pkg::PORT_IDATA: ram_wr = 1'b1;
                     default: ;
                  endcase
               end
            end
         endcase
      end else begin
         case (head_item.func)
            bdsp_pkg::FN_TICK: begin
               if (head_item.clear_halt) begin
                  hstat_in = 16'd0;
               end
               // Printer handshake step
               if (attached_ff) begin
                  pst = pstat_ff & bdsp_pkg::PSTAT_DONE_BUSY;
                  if (pst == bdsp_pkg::PSTAT_BUSY) begin
                     pstat_in = pstat_ff | bdsp_pkg::PSTAT_DONE;
                     irq_in   = pstat_ff[6];
                  end else if (pst == 15'd0) begin
                     strb_in  = 1'b1;
                     pbyte_in = pdata_ff;
                     pstat_in = pstat_ff | bdsp_pkg::PSTAT_BUSY;
                  end
               end
            end
            bdsp_pkg::FN_KEY: begin
               if (head_item.key_pressed) begin
                  hstat_in = hstat_ff | bdsp_pkg::KEY_FLAG | {8'd0, head_item.wdata[7:0]};
                  hreq_in  = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // RAM with byte lanes and registered read
   always_ff @(posedge clock) begin
      if (fire && ram_wr) begin
         if (ram_be[0]) ram_mem[ram_addr][7:0]  <= ram_wd[7:0];
         if (ram_be[1]) ram_mem[ram_addr][15:8] <= ram_wd[15:8];
      end
      if (fire && ram_rd) begin
         ram_q_ff <= ram_mem[ram_addr];
      end
   end

   // ROM: loaded by word index, read by bus address
   always_ff @(posedge clock) begin
      if (fire && head_item.func == bdsp_pkg::FN_ROM_LD) begin
         rom_mem[head_item.address[bdsp_pkg::ROM_AW-1:0]] <= head_item.wdata;
      end
      if (fire && rom_rd) begin
         rom_q_ff <= rom_mem[head_item.address[bdsp_pkg::ROM_AW:1]];
      end
   end

   // Port registers, config and result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         attached_ff <= 1'b0;
         hstat_ff    <= bdsp_pkg::HALT_STATUS_RST;
         iaddr_ff    <= 16'd0;
         pstat_ff    <= bdsp_pkg::PSTAT_RST;
         pdata_ff    <= 8'd0;
         valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            attached_ff <= csr_wdata;
         end
         if (fire) begin
            hstat_ff <= hstat_in;
            iaddr_ff <= iaddr_in;
            pstat_ff <= pstat_in;
            pdata_ff <= pdata_in;
         end
         if (fire) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Hold result payload
   always_ff @(posedge clock) begin
      if (fire) begin
         src_ff   <= src_in;
         bsel_ff  <= bsel_in;
         odd_ff   <= odd_in;
         rval_ff  <= rval_in;
         kind_ff  <= kind_in;
         err_ff   <= err_in;
         hreq_ff  <= hreq_in;
         hmw_ff   <= hmw_in;
         hmv_ff   <= hmv_in;
         strb_ff  <= strb_in;
         pbyte_ff <= pbyte_in;
         irq_ff   <= irq_in;
      end
   end

   // Select read data and byte lane
   always_comb begin
      case (src_ff)
         SRC_RAM: rword = ram_q_ff;
         SRC_ROM: rword = rom_q_ff;
         default: rword = rval_ff;
      endcase
      if (bsel_ff) begin
         rsp_rdata = odd_ff ? {8'd0, rword[15:8]} : {8'd0, rword[7:0]};
      end else begin
         rsp_rdata = rword;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_addr_kind       = kind_ff;
   assign rsp_mem_error       = err_ff;
   assign rsp_halt_request    = hreq_ff;
   assign rsp_halt_mode_write = hmw_ff;
   assign rsp_halt_mode_value = hmv_ff;
   assign rsp_printer_strobe  = strb_ff;
   assign rsp_printer_byte    = pbyte_ff;
   assign rsp_printer_irq     = irq_ff;

endmodule

// File: hw/rtl/bus_decode_and_system_ports_top.sv
// Top level of the bus decode and system ports block.
// Takes one bus word per cycle (read, write, tick, key event, ROM load) and
// returns exactly one response word for each. The front end decodes the
// address and holds up to two words in a queue; the back end executes one
// word per cycle when the response side does not stall, against the port
// flops and a synchronous RAM and ROM with registered read, so each word
// passes the queue register and then the result register. The request side
// stalls only when the queue is full. RAM and ROM contents are undefined
// until written; there is no clearing pass.
module bus_decode_and_system_ports_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [15:0] req_address,
   input  logic [15:0] req_wdata,
   input  logic        req_halt_mode,
   input  logic        req_key_pressed,
   input  logic        req_clear_halt,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_rdata,
   output logic [1:0]  rsp_addr_kind,
   output logic        rsp_mem_error,
   output logic        rsp_halt_request,
   output logic        rsp_halt_mode_write,
   output logic        rsp_halt_mode_value,
   output logic        rsp_printer_strobe,
   output logic [7:0]  rsp_printer_byte,
   output logic        rsp_printer_irq
);

   logic               head_valid;
   logic               head_pop;
   bdsp_pkg::item_type head_item;

   bdsp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_address     (req_address),
      .req_wdata       (req_wdata),
      .req_halt_mode   (req_halt_mode),
      .req_key_pressed (req_key_pressed),
      .req_clear_halt  (req_clear_halt),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .head_pop        (head_pop)
   );

   bdsp_back u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .head_valid          (head_valid),
      .head_item           (head_item),
      .head_pop            (head_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_rdata           (rsp_rdata),
      .rsp_addr_kind       (rsp_addr_kind),
      .rsp_mem_error       (rsp_mem_error),
      .rsp_halt_request    (rsp_halt_request),
      .rsp_halt_mode_write (rsp_halt_mode_write),
      .rsp_halt_mode_value (rsp_halt_mode_value),
      .rsp_printer_strobe  (rsp_printer_strobe),
      .rsp_printer_byte    (rsp_printer_byte),
      .rsp_printer_irq     (rsp_printer_irq)
   );

endmodule

// File: hw/rtl/bdsp_checker.sv
// Port-level checks for the bus decode and system ports block, with bind.
module bdsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_rdata,
   input logic [1:0]  rsp_addr_kind,
   input logic        rsp_mem_error,
   input logic        rsp_halt_mode_write,
   input logic        rsp_halt_mode_value,
   input logic        rsp_printer_strobe,
   input logic [7:0]  rsp_printer_byte
);

   // Stalled response word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rdata))
      else $error("stalled response changed");

   // No printer byte without strobe
   a_pbyte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_printer_strobe |-> rsp_printer_byte == 8'd0)
      else $error("printer byte without strobe");

   // Halt mode write only from a port access, value only with write
   a_hmw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_halt_mode_write || rsp_halt_mode_value) |->
      rsp_halt_mode_write && rsp_addr_kind == bdsp_pkg::KIND_IO)
      else $error("halt mode write outside port access");

   // Bus error only on ROM or port access
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mem_error |->
      rsp_addr_kind == bdsp_pkg::KIND_ROM || rsp_addr_kind == bdsp_pkg::KIND_IO)
      else $error("bus error on RAM or trap access");

endmodule

bind bus_decode_and_system_ports_top bdsp_checker u_bdsp_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_rdata           (rsp_rdata),
   .rsp_addr_kind       (rsp_addr_kind),
   .rsp_mem_error       (rsp_mem_error),
   .rsp_halt_mode_write (rsp_halt_mode_write),
   .rsp_halt_mode_value (rsp_halt_mode_value),
   .rsp_printer_strobe  (rsp_printer_strobe),
   .rsp_printer_byte    (rsp_printer_byte)
);
